// ----- rtl/core/cbpg_pkg.sv -----
`default_nettype none

package cbpg_pkg;

	localparam int REG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int GROUP_PIXELS = 8;

	typedef enum logic [REG_INDEX_W-1:0] {
		REG_CONTROL_ONE       = 3'd0,
		REG_CONTROL_TWO       = 3'd1,
		REG_MEMORY_SETUP      = 3'd2,
		REG_BANK_PORT         = 3'd3,
		REG_BORDER_COLOR      = 3'd4,
		REG_BACKGROUND_COLORS = 3'd5
	} reg_index_t;

	localparam logic [15:0] COLOR_RAM_BASE = 16'hD800;

	typedef struct packed {
		logic [7:0]  control_one;
		logic [7:0]  control_two;
		logic [7:0]  memory_setup;
		logic [1:0]  bank_port;
		logic [3:0]  border_color;
		logic [15:0] background_colors;
	} cfg_t;

	typedef struct packed {
		logic [5:0] cell_column;
		logic [4:0] cell_row;
		logic [2:0] cell_line;
		logic [7:0] screen_byte;
		logic [3:0] color_nibble;
		logic [7:0] pattern_byte;
		logic       border_group;
	} cell_t;

	typedef struct packed {
		logic [3:0]  color_index;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic        last_pixel;
		logic [15:0] screen_address;
		logic [15:0] color_address;
		logic [15:0] pattern_address;
	} pixel_t;

	typedef struct packed {
		logic [GROUP_PIXELS-1:0][3:0] pix;
		logic [15:0]                  screen_address;
		logic [15:0]                  color_address;
		logic [15:0]                  pattern_address;
	} group_t;

	function automatic logic [3:0] bg_pick(input logic [15:0] bgs, input logic [1:0] n);
		logic [3:0] r;
		case (n)
			2'd0: r = bgs[3:0];
			2'd1: r = bgs[7:4];
			2'd2: r = bgs[11:8];
			2'd3: r = bgs[15:12];
			default: r = bgs[3:0];
		endcase
		return r;
	endfunction

	function automatic logic [23:0] palette_rgb(input logic [3:0] ci);
		logic [23:0] r;
		case (ci)
			4'd0:  r = 24'h000000;
			4'd1:  r = 24'hFFFFFF;
			4'd2:  r = 24'h880000;
			4'd3:  r = 24'hAAFFEE;
			4'd4:  r = 24'hCC44CC;
			4'd5:  r = 24'h00CC55;
			4'd6:  r = 24'h0000AA;
			4'd7:  r = 24'hEEEE77;
			4'd8:  r = 24'hDD8855;
			4'd9:  r = 24'h664400;
			4'd10: r = 24'hFF7777;
			4'd11: r = 24'h333333;
			4'd12: r = 24'h777777;
			4'd13: r = 24'hAAFF66;
			4'd14: r = 24'h0088FF;
			4'd15: r = 24'hBBBBBB;
			default: r = 24'h000000;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/character_bitmap_pixel_generator.sv -----
// Text and bitmap pixel generator for a 40x25 cell display. Each accepted item is one
// eight-pixel line of one cell; the block returns its eight pixels left to right on
// consecutive cycles, each marked by strobe, with last_pixel set on the eighth. When the
// shifter is idle, an accepted item passes the input register, then the group register,
// before its first pixel is on the ports. Every pixel carries its palette index, the RGB
// value of the fixed palette and the cell's screen, color and pattern fetch addresses. The
// pixel shifter emits one pixel per cycle and takes the next item with the last pixel of
// the current one; one further item is held in the input register while the shifter
// works, and busy is high while that register is occupied. The receiver cannot stall:
// each pixel is on the ports for exactly one cycle. The user must write registers through
// wr_en, wr_index and wr_data only while no item is in flight; it is not enforced.
`default_nettype none

module character_bitmap_pixel_generator import cbpg_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  cell_t                  cell_data,
	output logic                   strobe,
	output pixel_t                 pixel,
	input  logic                   wr_en,
	input  logic [REG_INDEX_W-1:0] wr_index,
	input  logic [CFG_DATA_W-1:0]  wr_data
);

	cfg_t   cfg_q;
	cell_t  cell_s1;
	logic   valid_s1;
	logic   take;
	group_t grp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_CONTROL_ONE:       cfg_q.control_one       <= wr_data[7:0];
				REG_CONTROL_TWO:       cfg_q.control_two       <= wr_data[7:0];
				REG_MEMORY_SETUP:      cfg_q.memory_setup      <= wr_data[7:0];
				REG_BANK_PORT:         cfg_q.bank_port         <= wr_data[1:0];
				REG_BORDER_COLOR:      cfg_q.border_color      <= wr_data[3:0];
				REG_BACKGROUND_COLORS: cfg_q.background_colors <= wr_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (start && !valid_s1) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !valid_s1) begin
			cell_s1 <= cell_data;
		end
	end

	assign busy = valid_s1;

	cbpg_decode u_decode (
		.cfg       (cfg_q),
		.cell_data (cell_s1),
		.grp       (grp)
	);

	cbpg_serializer u_serializer (
		.clk       (clk),
		.arst_n    (arst_n),
		.grp_valid (valid_s1),
		.grp       (grp),
		.grp_take  (take),
		.strobe    (strobe),
		.pixel     (pixel)
	);

endmodule

`default_nettype wire

// ----- rtl/core/cbpg_decode.sv -----
`default_nettype none

module cbpg_decode import cbpg_pkg::*; (
	input  cfg_t   cfg,
	input  cell_t  cell_data,
	output group_t grp
);

	logic        ecm, bmm, den, mcm;
	logic [15:0] bank, scr_base, chr_base, bm_base;
	logic [10:0] cell_idx;
	logic [3:0]  fg, bg;
	logic [15:0] scr_addr, col_addr, pat_addr;
	logic [GROUP_PIXELS-1:0][3:0] pix;

	assign ecm = cfg.control_one[6];
	assign bmm = cfg.control_one[5];
	assign den = cfg.control_one[4];
	assign mcm = cfg.control_two[4];

	assign bank     = {~cfg.bank_port, 14'd0};
	assign scr_base = bank + {2'd0, cfg.memory_setup[7:4], 10'd0};
	assign chr_base = bank + {2'd0, cfg.memory_setup[3:1], 11'd0};
	assign bm_base  = bank + {2'd0, cfg.memory_setup[3], 13'd0};

	assign cell_idx = {1'b0, cell_data.cell_row, 5'd0} + {3'd0, cell_data.cell_row, 3'd0}
		+ {5'd0, cell_data.cell_column};

	assign fg = cell_data.screen_byte[7:4];
	assign bg = cell_data.screen_byte[3:0];

	assign scr_addr = scr_base + {5'd0, cell_idx};
	assign col_addr = COLOR_RAM_BASE + {5'd0, cell_idx};

	always_comb begin
		if (bmm) begin
			pat_addr = bm_base + {2'd0, cell_idx, cell_data.cell_line};
		end else if (ecm) begin
			pat_addr = chr_base
				+ {7'd0, cell_data.screen_byte[5:0], cell_data.cell_line};
		end else begin
			pat_addr = chr_base + {5'd0, cell_data.screen_byte, cell_data.cell_line};
		end
	end

	for (genvar p = 0; p < GROUP_PIXELS; p++) begin : g_pix
		localparam int HI_BIT  = GROUP_PIXELS - 1 - p;
		localparam int SEL_BIT = GROUP_PIXELS - 1 - 2 * (p / 2);
		logic       hi;
		logic [1:0] sel;
		logic [3:0] ci;

		assign hi  = cell_data.pattern_byte[HI_BIT];
		assign sel = cell_data.pattern_byte[SEL_BIT -: 2];

		always_comb begin
			if (cell_data.border_group || !den) begin
				ci = cfg.border_color;
			end else if (!bmm) begin
				if (ecm) begin
					ci = hi ? cell_data.color_nibble
						: bg_pick(cfg.background_colors, cell_data.screen_byte[7:6]);
				end else if (mcm && cell_data.color_nibble[3]) begin
					ci = (sel == 2'd3) ? {1'b0, cell_data.color_nibble[2:0]}
						: bg_pick(cfg.background_colors, sel);
				end else begin
					ci = hi ? cell_data.color_nibble : cfg.background_colors[3:0];
				end
			end else if (!mcm) begin
				ci = hi ? fg : bg;
			end else begin
				case (sel)
					2'd0: ci = cfg.background_colors[3:0];
					2'd1: ci = fg;
					2'd2: ci = bg;
					default: ci = cell_data.color_nibble;
				endcase
			end
		end

		assign pix[p] = ci;
	end

	assign grp = {pix, scr_addr, col_addr, pat_addr};

endmodule

`default_nettype wire

// ----- rtl/core/cbpg_shifter.sv -----
`default_nettype none

`default_nettype wire

// ----- rtl/core/cbpg_serializer.sv -----
`default_nettype none

module cbpg_serializer import cbpg_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   grp_valid,
	input  group_t grp,
	output logic   grp_take,
	output logic   strobe,
	output pixel_t pixel
);

	localparam int CNT_W = $clog2(GROUP_PIXELS);
	localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(GROUP_PIXELS - 1);

	group_t           grp_q;
	logic [CNT_W-1:0] cnt_q;
	logic             active_q;
	logic [3:0]       ci;
	logic [23:0]      rgb;

	assign grp_take = grp_valid && (!active_q || cnt_q == LAST_CNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= '0;
		end else if (grp_take) begin
			active_q <= 1'b1;
			cnt_q    <= '0;
		end else if (active_q) begin
			if (cnt_q == LAST_CNT) begin
				active_q <= 1'b0;
			end
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (grp_take) begin
			grp_q <= grp;
		end
	end

	assign ci  = grp_q.pix[cnt_q];
	assign rgb = palette_rgb(ci);

	assign strobe                = active_q;
	assign pixel.color_index     = ci;
	assign pixel.red             = rgb[23:16];
	assign pixel.green           = rgb[15:8];
	assign pixel.blue            = rgb[7:0];
	assign pixel.last_pixel      = (cnt_q == LAST_CNT);
	assign pixel.screen_address  = grp_q.screen_address;
	assign pixel.color_address   = grp_q.color_address;
	assign pixel.pattern_address = grp_q.pattern_address;

endmodule

`default_nettype wire

// ----- rtl/core/cbpg_checker.sv -----
`default_nettype none

module cbpg_checker import cbpg_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   start,
	input logic                   busy,
	input cell_t                  cell_data,
	input logic                   strobe,
	input pixel_t                 pixel,
	input logic                   wr_en,
	input logic [REG_INDEX_W-1:0] wr_index,
	input logic [CFG_DATA_W-1:0]  wr_data
);

	logic unused_ok;
	assign unused_ok = ^{cell_data, wr_en, wr_index, wr_data};

	a_accept_holds: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not occupy the input register");

	a_group_continues: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !pixel.last_pixel |=> strobe)
		else $error("pixel group interrupted before its last pixel");

	a_addr_stable: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !pixel.last_pixel |=> $stable(pixel.screen_address)
			&& $stable(pixel.color_address) && $stable(pixel.pattern_address))
		else $error("fetch addresses changed within a pixel group");

	a_idle_launch: assert property (@(posedge clk) disable iff (!arst_n)
		busy && !strobe |=> strobe && !busy)
		else $error("waiting item not launched into an idle shifter");

endmodule

bind character_bitmap_pixel_generator cbpg_checker u_checker (.*);

`default_nettype wire

// ----- bench/tb_character_bitmap_pixel_generator.sv -----
`timescale 1ns / 1ps

module tb_character_bitmap_pixel_generator;
	import cbpg_pkg::*;

	localparam int QUIET_LIMIT = 1000;

	localparam logic [16*24-1:0] PALETTE = {
		24'hBBBBBB, 24'h0088FF, 24'hAAFF66, 24'h777777,
		24'h333333, 24'hFF7777, 24'h664400, 24'hDD8855,
		24'hEEEE77, 24'h0000AA, 24'h00CC55, 24'hCC44CC,
		24'hAAFFEE, 24'h880000, 24'hFFFFFF, 24'h000000
	};

	logic                   clk;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	cell_t                  cell_in;
	logic                   strobe;
	pixel_t                 pixel_out;
	logic                   wr_en;
	logic [REG_INDEX_W-1:0] wr_index;
	logic [CFG_DATA_W-1:0]  wr_data;

	cfg_t   regs_now;
	pixel_t pending_pixels[$];
	pixel_t want_px;
	int     errors;
	int     mismatches;
	int     cells_sent;
	int     pixels_seen;
	int     quiet_cycles;
	bit     gaps_on;

	character_bitmap_pixel_generator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cell_data (cell_in),
		.strobe    (strobe),
		.pixel     (pixel_out),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [3:0] bg_nibble(input logic [15:0] bgs, input logic [1:0] n);
		return bgs[n*4 +: 4];
	endfunction

	task automatic render_cell(input cell_t c);
		logic [1:0]  bank_sel;
		int unsigned bank;
		int unsigned scr_base;
		int unsigned chr_base;
		int unsigned bm_base;
		int unsigned cell_idx;
		int unsigned code;
		logic [15:0] scr_a;
		logic [15:0] col_a;
		logic [15:0] pat_a;
		logic        ecm;
		logic        bmm;
		logic        den;
		logic        mcm;
		logic        hi;
		logic [1:0]  sel;
		logic [3:0]  fg;
		logic [3:0]  bg;
		logic [3:0]  cr;
		logic [3:0]  ci;
		pixel_t      px;
		ecm = regs_now.control_one[6];
		bmm = regs_now.control_one[5];
		den = regs_now.control_one[4];
		mcm = regs_now.control_two[4];
		bank_sel = ~regs_now.bank_port;
		bank = bank_sel * 32'h4000;
		scr_base = bank + regs_now.memory_setup[7:4] * 32'd1024;
		chr_base = bank + regs_now.memory_setup[3:1] * 32'd2048;
		bm_base = bank + regs_now.memory_setup[3] * 32'h2000;
		cell_idx = c.cell_row * 32'd40 + c.cell_column;
		code = ecm ? 32'(c.screen_byte[5:0]) : 32'(c.screen_byte);
		scr_a = 16'(scr_base + cell_idx);
		col_a = 16'(32'hD800 + cell_idx);
		if (bmm) begin
			pat_a = 16'(bm_base + cell_idx * 32'd8 + c.cell_line);
		end else begin
			pat_a = 16'(chr_base + code * 32'd8 + c.cell_line);
		end
		fg = c.screen_byte[7:4];
		bg = c.screen_byte[3:0];
		cr = c.color_nibble;
		for (int p = 0; p < 8; p++) begin
			hi = c.pattern_byte[7-p];
			sel = c.pattern_byte[7-2*(p/2) -: 2];
			if (c.border_group || !den) begin
				ci = regs_now.border_color;
			end else if (!bmm) begin
				if (ecm) begin
					ci = hi ? cr : bg_nibble(regs_now.background_colors, c.screen_byte[7:6]);
				end else if (mcm && cr[3]) begin
					ci = (sel == 2'd3) ? {1'b0, cr[2:0]} :
						bg_nibble(regs_now.background_colors, sel);
				end else begin
					ci = hi ? cr : bg_nibble(regs_now.background_colors, 2'd0);
				end
			end else if (!mcm) begin
				ci = hi ? fg : bg;
			end else begin
				case (sel)
					2'd0: ci = bg_nibble(regs_now.background_colors, 2'd0);
					2'd1: ci = fg;
					2'd2: ci = bg;
					default: ci = cr;
				endcase
			end
			px.color_index = ci;
			{px.red, px.green, px.blue} = PALETTE[ci*24 +: 24];
			px.last_pixel = (p == 7);
			px.screen_address = scr_a;
			px.color_address = col_a;
			px.pattern_address = pat_a;
			pending_pixels.push_back(px);
		end
	endtask

	task automatic report_mismatch(input string what, input pixel_t want, input pixel_t got);
		mismatches++;
		errors++;
		if (mismatches <= 10) begin
			$display("%0t %s: want ci=%h rgb=%h%h%h last=%b scr=%h col=%h pat=%h",
				$time, what, want.color_index, want.red, want.green, want.blue,
				want.last_pixel, want.screen_address, want.color_address,
				want.pattern_address);
			$display("%0t %s: got  ci=%h rgb=%h%h%h last=%b scr=%h col=%h pat=%h",
				$time, what, got.color_index, got.red, got.green, got.blue,
				got.last_pixel, got.screen_address, got.color_address,
				got.pattern_address);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && strobe) begin
			pixels_seen++;
			if (pending_pixels.size() == 0) begin
				report_mismatch("unexpected pixel", '0, pixel_out);
			end else begin
				want_px = pending_pixels.pop_front();
				if (pixel_out.color_index !== want_px.color_index ||
						pixel_out.red !== want_px.red ||
						pixel_out.green !== want_px.green ||
						pixel_out.blue !== want_px.blue ||
						pixel_out.last_pixel !== want_px.last_pixel ||
						pixel_out.screen_address !== want_px.screen_address ||
						pixel_out.color_address !== want_px.color_address ||
						pixel_out.pattern_address !== want_px.pattern_address) begin
					report_mismatch("pixel mismatch", want_px, pixel_out);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe || wr_en) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic cell_t make_cell(input int col, input int row, input int line,
			input logic [7:0] sc, input logic [3:0] cr, input logic [7:0] pat,
			input bit brd);
		cell_t c;
		c.cell_column = 6'(col);
		c.cell_row = 5'(row);
		c.cell_line = 3'(line);
		c.screen_byte = sc;
		c.color_nibble = cr;
		c.pattern_byte = pat;
		c.border_group = brd;
		return c;
	endfunction

	function automatic cell_t random_cell();
		cell_t c;
		bit    wild;
		wild = ($urandom_range(9) == 0);
		c.cell_column = 6'(wild ? $urandom_range(63) : $urandom_range(39));
		c.cell_row = 5'(wild ? $urandom_range(31) : $urandom_range(24));
		c.cell_line = 3'($urandom_range(7));
		c.screen_byte = 8'($urandom_range(255));
		c.color_nibble = 4'($urandom_range(15));
		c.pattern_byte = 8'($urandom_range(255));
		c.border_group = ($urandom_range(9) == 0);
		return c;
	endfunction

	// The start line is left high after an item is taken, so every path that lets
	// time pass without sending must lower it in the same step.
	task automatic send_cell(input cell_t c);
		int gap;
		if (gaps_on && $urandom_range(99) < 25) begin
			gap = $urandom_range(8, 1);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cell_in <= c;
		do @(posedge clk); while (busy);
		render_cell(c);
		cells_sent++;
	endtask

	task automatic wait_drain();
		start <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] data);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [7:0] c1, input logic [7:0] c2,
			input logic [7:0] ms, input logic [1:0] bank, input logic [3:0] border,
			input logic [15:0] bgs);
		wait_drain();
		write_reg(REG_CONTROL_ONE, {8'd0, c1});
		write_reg(REG_CONTROL_TWO, {8'd0, c2});
		write_reg(REG_MEMORY_SETUP, {8'd0, ms});
		write_reg(REG_BANK_PORT, {14'd0, bank});
		write_reg(REG_BORDER_COLOR, {12'd0, border});
		write_reg(REG_BACKGROUND_COLORS, bgs);
		wr_en <= 1'b0;
		regs_now.control_one = c1;
		regs_now.control_two = c2;
		regs_now.memory_setup = ms;
		regs_now.bank_port = bank;
		regs_now.border_color = border;
		regs_now.background_colors = bgs;
	endtask

	task automatic test_after_reset();
		send_cell(make_cell(5, 3, 2, 8'hC3, 4'hA, 8'h96, 1'b0));
		send_cell(make_cell(39, 24, 7, 8'hFF, 4'hF, 8'hFF, 1'b0));
	endtask

	task automatic test_standard_text();
		set_config(8'h1B, 8'hC8, 8'h00, 2'd3, 4'd14, 16'h0000);
		send_cell(make_cell(0, 0, 0, 8'h00, 4'h0, 8'hFF, 1'b0));
		send_cell(make_cell(39, 24, 7, 8'hFF, 4'hF, 8'h00, 1'b0));
		send_cell(make_cell(20, 12, 3, 8'h5A, 4'h7, 8'hA5, 1'b0));
	endtask

	task automatic test_multicolor_text();
		set_config(8'h10, 8'h10, 8'hFF, 2'd0, 4'd3, 16'h4321);
		send_cell(make_cell(1, 1, 1, 8'h11, 4'hF, 8'h1B, 1'b0));
		send_cell(make_cell(38, 23, 6, 8'hEE, 4'h8, 8'hE4, 1'b0));
		send_cell(make_cell(10, 5, 4, 8'h80, 4'h7, 8'h1B, 1'b0));
	endtask

	task automatic test_extended_color();
		set_config(8'h50, 8'h10, 8'h2A, 2'd1, 4'd0, 16'hFEDC);
		send_cell(make_cell(7, 2, 0, 8'h3F, 4'h1, 8'h69, 1'b0));
		send_cell(make_cell(8, 2, 1, 8'h40, 4'h9, 8'h69, 1'b0));
		send_cell(make_cell(9, 2, 2, 8'h80, 4'hC, 8'h69, 1'b0));
		send_cell(make_cell(10, 2, 3, 8'hFF, 4'hE, 8'h69, 1'b0));
	endtask

	task automatic test_bitmap();
		set_config(8'h30, 8'h00, 8'h08, 2'd2, 4'd5, 16'h000F);
		send_cell(make_cell(0, 0, 0, 8'h1E, 4'h3, 8'hF0, 1'b0));
		send_cell(make_cell(39, 24, 7, 8'hD2, 4'hB, 8'h3C, 1'b0));
		set_config(8'h30, 8'h10, 8'hF7, 2'd3, 4'd5, 16'h000A);
		send_cell(make_cell(15, 9, 5, 8'h47, 4'hD, 8'h1B, 1'b0));
		send_cell(make_cell(33, 17, 2, 8'hB9, 4'h6, 8'hE4, 1'b0));
		set_config(8'h70, 8'h10, 8'h5E, 2'd1, 4'd12, 16'h9876);
		send_cell(make_cell(4, 20, 6, 8'h7C, 4'h2, 8'h1B, 1'b0));
		set_config(8'h70, 8'h00, 8'h5E, 2'd1, 4'd12, 16'h9876);
		send_cell(make_cell(25, 4, 1, 8'h3D, 4'h4, 8'hC6, 1'b0));
	endtask

	task automatic test_border_and_disable();
		set_config(8'h1F, 8'h00, 8'h55, 2'd1, 4'd15, 16'hFFFF);
		send_cell(make_cell(12, 12, 4, 8'hAB, 4'hC, 8'h5A, 1'b1));
		set_config(8'hEF, 8'hFF, 8'hAA, 2'd2, 4'd15, 16'hFFFF);
		send_cell(make_cell(30, 20, 5, 8'h12, 4'h3, 8'hA5, 1'b0));
	endtask

	task automatic test_out_of_range();
		set_config(8'h10, 8'h00, 8'hFF, 2'd0, 4'd9, 16'h1234);
		send_cell(make_cell(63, 31, 7, 8'hFF, 4'hF, 8'hFF, 1'b0));
		send_cell(make_cell(40, 25, 0, 8'h00, 4'h0, 8'h00, 1'b0));
	endtask

	task automatic test_random_phases();
		logic [7:0] c1;
		logic [7:0] c2;
		int         mode;
		for (int phase = 0; phase < 8; phase++) begin
			mode = phase % 6;
			c1 = 8'($urandom_range(255));
			c2 = 8'($urandom_range(255));
			if (mode != 5) begin
				c1[4] = ($urandom_range(7) != 0);
			end
			case (mode)
				0: begin
					c1[6:5] = 2'b00;
					c2[4] = 1'b0;
				end
				1: begin
					c1[6:5] = 2'b00;
					c2[4] = 1'b1;
				end
				2: c1[6:5] = 2'b10;
				3: begin
					c1[5] = 1'b1;
					c2[4] = 1'b0;
				end
				4: begin
					c1[5] = 1'b1;
					c2[4] = 1'b1;
				end
				default: ;
			endcase
			gaps_on = (phase != 3);
			set_config(c1, c2, 8'($urandom_range(255)), 2'($urandom_range(3)),
				4'($urandom_range(15)), 16'($urandom_range(65535)));
			for (int k = 0; k < 23; k++) begin
				if (k == 11) begin
					wait_drain();
				end
				send_cell(random_cell());
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		cell_in <= '0;
		wr_en <= 1'b0;
		wr_index <= '0;
		wr_data <= '0;
		regs_now = '0;
		errors = 0;
		mismatches = 0;
		cells_sent = 0;
		pixels_seen = 0;
		gaps_on = 1'b1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_after_reset();
		test_standard_text();
		test_multicolor_text();
		test_extended_color();
		test_bitmap();
		test_border_and_disable();
		test_out_of_range();
		test_random_phases();

		wait_drain();
		repeat (16) @(posedge clk);
		if (pending_pixels.size() != 0) begin
			errors += pending_pixels.size();
			$display("%0d pixels never arrived", pending_pixels.size());
		end
		$display("Sent %0d cells and checked %0d pixels, %0d mismatches.",
			cells_sent, pixels_seen, mismatches);
		$display("Covered text, multicolor, extended color and bitmap modes, border and blanking.");
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/cbpg_pkg.sv
rtl/core/cbpg_decode.sv
rtl/core/cbpg_shifter.sv
rtl/core/cbpg_serializer.sv
rtl/core/character_bitmap_pixel_generator.sv
rtl/core/cbpg_checker.sv
bench/tb_character_bitmap_pixel_generator.sv
